@@ design/wste_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wste_pkg
// Shared types and constants of the weighted sampling tree engine.
// ----------------------------------------------------------------------------
package wste_pkg;

  localparam int WB        = 32;          // weight width
  localparam int TREES     = 26;
  localparam int LEAVES    = 729;
  localparam int RADIX     = 9;
  localparam int SUMS      = RADIX - 1;   // left sums per node
  localparam int LEVELS    = 3;           // internal levels
  localparam int INTERNAL  = 91;          // internal nodes per tree
  localparam int ROWS      = TREES * INTERNAL;
  localparam int AW        = $clog2(ROWS);

  typedef enum logic [1:0] {
    CMD_ADD       = 2'd0,
    CMD_SUB       = 2'd1,
    CMD_SAMPLE    = 2'd2,
    CMD_SAMPLE_RM = 2'd3
  } cmd_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EX
  } bstate_t;

  typedef logic [SUMS-1:0][WB-1:0] row_t;
  typedef logic [LEVELS-1:0][3:0]  digits_t;   // [0] is the root's child

  typedef struct packed {
    cmd_t             cmd;
    logic             tree_ok;
    logic             leaf_ok;
    logic [4:0]       tree;
    logic [AW-1:0]    base;
    digits_t          dig;
    logic [WB-1:0]    delta;
    logic [WB-1:0]    query;
  } qent_t;

endpackage

@@ design/wste_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wste_front
// Classifies an incoming item: range checks, leaf path digits, row base.
// ----------------------------------------------------------------------------
module wste_front (
  input  logic [1:0]           cmd,
  input  logic [4:0]           tree_select,
  input  logic [9:0]           leaf,
  input  logic [31:0]          delta,
  input  logic [31:0]          query,
  output wste_pkg::qent_t      ent
);
  import wste_pkg::*;

  logic [3:0] d2, d1, d0;
  logic [9:0] r1;

  always_comb begin
    d2 = '0;
    for (int k = 1; k < RADIX; k++) begin
      d2 = d2 + 4'(leaf >= 10'(k * RADIX * RADIX));
    end
    r1 = leaf - 10'(d2) * 10'(RADIX * RADIX);
    d1 = '0;
    for (int k = 1; k < RADIX; k++) begin
      d1 = d1 + 4'(r1 >= 10'(k * RADIX));
    end
    d0 = 4'(r1 - 10'(d1) * 10'(RADIX));

    ent.cmd     = cmd_t'(cmd);
    ent.tree_ok = tree_select < 5'(TREES);
    ent.leaf_ok = leaf < 10'(LEAVES);
    ent.tree    = tree_select;
    ent.base    = AW'(tree_select) * AW'(INTERNAL);
    ent.dig     = {d0, d1, d2};
    ent.delta   = delta;
    ent.query   = query;
  end

endmodule

@@ design/wste_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wste_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module wste_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wste_pkg::qent_t  din,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output wste_pkg::qent_t  dout
);
  import wste_pkg::*;

  qent_t      entries [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign dout     = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= din;
  end

endmodule

@@ design/wste_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wste_back
// Executes commands: node memory walks, running totals, result register.
// ----------------------------------------------------------------------------
module wste_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  wste_pkg::qent_t  q_ent,
  output logic             pop,
  output logic             clearing,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [1:0]       o_status,
  output logic [9:0]       o_chosen,
  output logic [31:0]      o_weight,
  output logic [31:0]      o_total
);
  import wste_pkg::*;

  row_t              mem [ROWS];
  row_t              rdata;
  logic [WB-1:0]     totals [TREES];
  logic [AW-1:0]     clr_cnt;

  bstate_t state, state_next;
  logic [1:0]    level, level_next;
  logic [6:0]    node, node_next;
  digits_t       dig, dig_next;
  logic [WB-1:0] q_r, q_next, s_r, s_next, delta_r, delta_next;
  logic          upd, upd_next, sub, sub_next, rm, rm_next;
  logic [4:0]    tree_r, tree_next;
  logic [AW-1:0] base_r, base_next;

  logic          rd_en, we, load, tot_we;
  logic [AW-1:0] raddr;
  row_t          row_new;
  logic [WB-1:0] tot_wval, tot_cur, tot_q, lm1, li, s_new;
  logic [3:0]    cnt, cdig;
  logic [6:0]    nn;
  logic [1:0]    ld_status;
  logic [9:0]    ld_chosen;
  logic [31:0]   ld_weight, ld_total;
  logic          is_samp;

  assign tot_cur = totals[tree_r];
  assign tot_q   = totals[q_ent.tree];
  assign is_samp = q_ent.cmd == CMD_SAMPLE || q_ent.cmd == CMD_SAMPLE_RM;

  always_comb begin
    // node evaluation on the row just read
    cnt = '0;
    for (int i = 0; i < SUMS; i++) begin
      cnt = cnt + 4'(rdata[i] <= q_r);
    end
    lm1   = (cnt != 4'd0) ? rdata[3'(cnt - 4'd1)] : '0;
    li    = (cnt != 4'(SUMS)) ? rdata[cnt[2:0]] : s_r;
    s_new = li - lm1;
    cdig  = upd ? dig[level] : cnt;
    nn    = 7'(node * 7'(RADIX)) + 7'(cdig) + 7'd1;
    for (int k = 0; k < SUMS; k++) begin
      if (4'(k) >= dig[level]) begin
        row_new[k] = sub ? rdata[k] - delta_r : rdata[k] + delta_r;
      end else begin
        row_new[k] = rdata[k];
      end
    end

    state_next = state;
    level_next = level;
    node_next  = node;
    dig_next   = dig;
    q_next     = q_r;
    s_next     = s_r;
    delta_next = delta_r;
    upd_next   = upd;
    sub_next   = sub;
    rm_next    = rm;
    tree_next  = tree_r;
    base_next  = base_r;
    pop        = 1'b0;
    rd_en      = 1'b0;
    raddr      = base_r + AW'(node);
    we         = 1'b0;
    tot_we     = 1'b0;
    tot_wval   = sub ? tot_cur - delta_r : tot_cur + delta_r;
    load       = 1'b0;
    ld_status  = STAT_OK;
    ld_chosen  = '0;
    ld_weight  = '0;
    ld_total   = '0;

    unique case (state)
      ST_IDLE: begin
        if (!clearing && q_nonempty && (!m_valid || m_ready)) begin
          pop        = 1'b1;
          tree_next  = q_ent.tree;
          base_next  = q_ent.base;
          level_next = 2'd0;
          node_next  = 7'd0;
          q_next     = q_ent.query;
          s_next     = tot_q;
          delta_next = q_ent.delta;
          rm_next    = q_ent.cmd == CMD_SAMPLE_RM;
          sub_next   = q_ent.cmd == CMD_SUB;
          if (!q_ent.tree_ok) begin
            load      = 1'b1;
            ld_status = is_samp ? STAT_EMPTY : STAT_OK;
          end else if (!is_samp) begin
            if (!q_ent.leaf_ok) begin
              load     = 1'b1;
              ld_total = tot_q;
            end else begin
              upd_next   = 1'b1;
              dig_next   = q_ent.dig;
              state_next = ST_RD;
            end
          end else if (tot_q == '0) begin
            load      = 1'b1;
            ld_status = STAT_EMPTY;
          end else if (q_ent.query >= tot_q) begin
            load      = 1'b1;
            ld_status = STAT_RANGE;
            ld_total  = tot_q;
          end else begin
            upd_next   = 1'b0;
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        rd_en      = 1'b1;
        state_next = ST_EX;
      end
      ST_EX: begin
        if (upd) begin
          we = 1'b1;
          if (level != 2'(LEVELS - 1)) begin
            // read the next level while this row is written back
            rd_en      = 1'b1;
            raddr      = base_r + AW'(nn);
            node_next  = nn;
            level_next = level + 2'd1;
          end else begin
            tot_we     = 1'b1;
            load       = 1'b1;
            ld_total   = tot_wval;
            if (rm) begin
              ld_chosen = 10'(dig[0]) * 10'(RADIX * RADIX) + 10'(dig[1]) * 10'(RADIX)
                          + 10'(dig[2]);
              ld_weight = delta_r;
            end
            state_next = ST_IDLE;
          end
        end else begin
          q_next          = q_r - lm1;
          s_next          = s_new;
          dig_next[level] = cnt;
          node_next       = nn;
          if (level != 2'(LEVELS - 1)) begin
            level_next = level + 2'd1;
            state_next = ST_RD;
          end else if (rm) begin
            // remove the sampled weight along the same path
            upd_next   = 1'b1;
            sub_next   = 1'b1;
            delta_next = s_new;
            level_next = 2'd0;
            node_next  = 7'd0;
            state_next = ST_RD;
          end else begin
            load       = 1'b1;
            ld_chosen  = 10'(dig[0]) * 10'(RADIX * RADIX) + 10'(dig[1]) * 10'(RADIX)
                         + 10'(cnt);
            ld_weight  = s_new;
            ld_total   = tot_cur;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      clearing <= 1'b1;
      clr_cnt  <= '0;
      m_valid  <= 1'b0;
      for (int i = 0; i < TREES; i++) totals[i] <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(ROWS - 1)) clearing <= 1'b0;
      end
      if (load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
      if (tot_we) totals[tree_r] <= tot_wval;
    end
  end

  always_ff @(posedge clk) begin
    level   <= level_next;
    node    <= node_next;
    dig     <= dig_next;
    q_r     <= q_next;
    s_r     <= s_next;
    delta_r <= delta_next;
    upd     <= upd_next;
    sub     <= sub_next;
    rm      <= rm_next;
    tree_r  <= tree_next;
    base_r  <= base_next;
    if (load) begin
      o_status <= ld_status;
      o_chosen <= ld_chosen;
      o_weight <= ld_weight;
      o_total  <= ld_total;
    end
  end

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_cnt] <= '0;
    else if (we) mem[base_r + AW'(node)] <= row_new;
    if (rd_en) rdata <= mem[raddr];
  end

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == ST_IDLE) else $error("work started during clearing pass");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!m_valid || m_ready)) else $error("item popped with result register busy");

  a_level: assert property (@(posedge clk) disable iff (rst)
    state == ST_EX |-> level != 2'd3) else $error("walk past leaf level");

  a_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD && level == 2'd0) |-> node == 7'd0) else $error("walk not from root");

endmodule

@@ design/weighted_sampling_tree_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_sampling_tree_engine
// 26 radix-9 left-sum trees with running totals: add, subtract, sample,
// sample-and-remove.
// ----------------------------------------------------------------------------
// channel  dir  tuser       tdata
// s_axis   in   cmd         tree_select, leaf, delta, query
// m_axis   out  status      chosen_leaf, pick_weight, tree_total
//
// Add/subtract: pop, one read, then one write per level with the next
// level's read overlapped. Sample: read then evaluate per level.
// Sample-and-remove: a sample walk, then a subtract walk on its path. After
// reset a clearing pass zeroes the node memory; no item is accepted
// meanwhile. A two-entry queue takes items while results stall.
// ----------------------------------------------------------------------------
module weighted_sampling_tree_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // cmd
  input  logic [79:0] s_axis_tdata,   // tree_select, leaf, delta, query, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // status
  output logic [79:0] m_axis_tdata    // chosen_leaf, pick_weight, tree_total, pad
);
  import wste_pkg::*;

  qent_t f_ent, q_ent;
  logic  q_full, q_nonempty, pop, clearing, push;
  logic [9:0]  o_chosen;
  logic [31:0] o_weight, o_total;

  assign s_axis_tready = !q_full && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {6'd0, o_total, o_weight, o_chosen};

  wste_front u_front (
    .cmd         (s_axis_tuser),
    .tree_select (s_axis_tdata[4:0]),
    .leaf        (s_axis_tdata[14:5]),
    .delta       (s_axis_tdata[46:15]),
    .query       (s_axis_tdata[78:47]),
    .ent         (f_ent)
  );

  wste_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (f_ent),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .dout     (q_ent)
  );

  wste_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_ent      (q_ent),
    .pop        (pop),
    .clearing   (clearing),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .o_status   (m_axis_tuser),
    .o_chosen   (o_chosen),
    .o_weight   (o_weight),
    .o_total    (o_total)
  );

endmodule

@@ verif/tb_weighted_sampling_tree_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_sampling_tree_engine
// Self-checking bench for the weighted sampling tree engine. A local model of
// the 26 radix-9 left-sum trees predicts every result, which is compared
// field by field in order. Directed cases come first: leaf and tree bounds,
// empty and over-range samples, and subtract wrap. A long random run of
// add/subtract/sample traffic follows, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_weighted_sampling_tree_engine;
  import wste_pkg::*;

  localparam int HEIGHT    = 3;
  localparam int NODE_SUMS = 8;
  localparam int NODES     = 91;
  localparam int LIMIT     = 300000;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  chosen;
    logic [31:0] weight;
    logic [31:0] total;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic [79:0] s_axis_tdata = '0;   // tree_select, leaf, delta, query, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;        // status
  logic [79:0] m_axis_tdata;        // chosen_leaf, pick_weight, tree_total, pad

  logic [31:0] node_sums [TREES*NODES*NODE_SUMS];
  logic [31:0] totals [TREES];
  outcome_t    pending [$];
  int          errors = 0;
  int          cycles = 0;
  int          rx_wait = 0;
  int          rx_hold = 0;
  bit          no_idle = 0;

  weighted_sampling_tree_engine dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("weighted_sampling_tree_engine: mismatch");
      $finish;
    end
  end

  // Receiver stalls: per-item random wait plus an optional long hold.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      m_axis_tready = 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tdata[73:42]};
      rx_wait = no_idle ? 0 : $urandom_range(0, 4);
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"result mismatch: exp st=%0d leaf=%0d w=%h tot=%h,",
                      " got st=%0d leaf=%0d w=%h tot=%h"},
                     want.status, want.chosen, want.weight, want.total,
                     got.status, got.chosen, got.weight, got.total);
        end
      end
    end
  end

  // Walk from leaf to root, adjusting every sum at or right of the path child.
  task automatic adjust_leaf(int tree, int leaf, logic [31:0] amt, bit minus);
    int cursor, parent, child, slot;
    cursor = leaf + NODES;
    for (int h = 0; h < HEIGHT; h++) begin
      parent = (cursor - 1) / RADIX;
      child  = cursor - 1 - RADIX * parent;
      for (int k = child; k < NODE_SUMS; k++) begin
        slot = (tree * NODES + parent) * NODE_SUMS + k;
        node_sums[slot] = minus ? node_sums[slot] - amt : node_sums[slot] + amt;
      end
      cursor = parent;
    end
  endtask

  task automatic predict_tree_op(cmd_t cmd, int tree, int leaf, logic [31:0] delta,
                                 logic [31:0] query, output outcome_t res);
    int cursor, c, nb;
    logic [31:0] q, s, lo, hi;
    res = '0;
    if (tree >= TREES) begin
      if (cmd == CMD_SAMPLE || cmd == CMD_SAMPLE_RM) res.status = STAT_EMPTY;
      return;
    end
    if (cmd == CMD_ADD || cmd == CMD_SUB) begin
      if (leaf < LEAVES) begin
        adjust_leaf(tree, leaf, delta, cmd == CMD_SUB);
        totals[tree] = (cmd == CMD_SUB) ? totals[tree] - delta : totals[tree] + delta;
      end
    end else if (totals[tree] == 0) begin
      res.status = STAT_EMPTY;
    end else if (query >= totals[tree]) begin
      res.status = STAT_RANGE;
    end else begin
      cursor = 0;
      q = query;
      s = totals[tree];
      for (int h = 0; h < HEIGHT; h++) begin
        nb = (tree * NODES + cursor) * NODE_SUMS;
        c = 0;
        for (int i = 0; i < NODE_SUMS; i++) if (node_sums[nb + i] <= q) c++;
        lo = (c > 0) ? node_sums[nb + c - 1] : '0;
        hi = (c < NODE_SUMS) ? node_sums[nb + c] : s;
        q = q - lo;
        s = hi - lo;
        cursor = RADIX * cursor + c + 1;
      end
      res.chosen = 10'(cursor - NODES);
      res.weight = s;
      if (cmd == CMD_SAMPLE_RM) begin
        adjust_leaf(tree, cursor - NODES, s, 1'b1);
        totals[tree] = totals[tree] - s;
      end
    end
    res.total = totals[tree];
  endtask

  task automatic send_item(cmd_t cmd, int tree, int leaf, logic [31:0] delta,
                           logic [31:0] query);
    int gap;
    outcome_t res;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = {1'b0, query, delta, leaf[9:0], tree[4:0]};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_tree_op(cmd, tree, leaf, delta, query, res);
    pending.push_back(res);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // Query below the current total where there is weight to draw from.
  function automatic logic [31:0] fair_query(int tree);
    if (tree >= TREES || totals[tree] == 0) return $urandom;
    return $urandom % totals[tree];
  endfunction

  task automatic test_leaf_bounds();
    send_item(CMD_ADD, 0, 0, 32'd5, '0);
    send_item(CMD_ADD, 0, 728, 32'd7, '0);
    send_item(CMD_ADD, 0, 729, 32'd100, '0);
    send_item(CMD_SUB, 0, 1023, 32'hffff_ffff, '1);
    send_item(CMD_ADD, 0, 364, 32'd3, '0);
    send_item(CMD_SAMPLE, 0, 0, '0, 32'd0);
    send_item(CMD_SAMPLE, 0, 0, '0, 32'd14);
    send_item(CMD_SAMPLE, 0, 0, '0, 32'd4);
  endtask

  task automatic test_bad_tree();
    send_item(CMD_ADD, 26, 5, 32'd9, '0);
    send_item(CMD_SUB, 31, 5, 32'd9, '0);
    send_item(CMD_SAMPLE, 31, 0, '0, 32'd0);
    send_item(CMD_SAMPLE_RM, 26, 0, '0, 32'd0);
  endtask

  task automatic test_sample_status();
    send_item(CMD_SAMPLE, 5, 0, '0, 32'd0);       // empty tree
    send_item(CMD_SAMPLE_RM, 5, 0, '0, '1);
    send_item(CMD_ADD, 5, 100, 32'hffff_ffff, '0);
    send_item(CMD_SAMPLE, 5, 0, '0, '1);          // query equals total
    send_item(CMD_SAMPLE, 5, 0, '0, 32'hffff_fffe);
    send_item(CMD_SAMPLE_RM, 5, 0, '0, 32'd0);
    send_item(CMD_SAMPLE, 5, 0, '0, 32'd0);
  endtask

  task automatic test_underflow();
    send_item(CMD_SUB, 7, 3, 32'd10, '0);         // wraps below zero
    send_item(CMD_SAMPLE, 7, 0, '0, 32'h8000_0000);
    send_item(CMD_SAMPLE_RM, 7, 0, '0, 32'd1);
    send_item(CMD_ADD, 7, 500, 32'h1234_5678, '0);
    send_item(CMD_SAMPLE_RM, 7, 0, '0, 32'h0000_0100);
  endtask

  task automatic random_item();
    int r, tree, leaf;
    r = $urandom_range(0, 99);
    tree = $urandom_range(0, TREES - 1);
    leaf = $urandom_range(0, LEAVES - 1);
    if (r < 40)
      send_item(CMD_ADD, tree, leaf, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1000), '0);
    else if (r < 50)
      send_item(CMD_SUB, tree, leaf, $urandom_range(0, 50), '0);
    else if (r < 72)
      send_item(CMD_SAMPLE, tree, 0, $urandom, fair_query(tree));
    else if (r < 94)
      send_item(CMD_SAMPLE_RM, tree, 0, $urandom, fair_query(tree));
    else
      send_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                $urandom_range(0, 1023), $urandom, $urandom);
  endtask

  // Long receiver hold while the sender keeps pushing: input must stall.
  task automatic test_backpressure();
    @(negedge clk);
    rx_hold = 80;
    repeat (12) random_item();
    drain();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 100) no_idle = 1;
      if (n % 300 == 160) no_idle = 0;
      random_item();
    end
    no_idle = 0;
  endtask

  initial begin
    for (int i = 0; i < TREES*NODES*NODE_SUMS; i++) node_sums[i] = '0;
    for (int i = 0; i < TREES; i++) totals[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_leaf_bounds();
    test_bad_tree();
    test_sample_status();
    test_underflow();
    drain();
    test_backpressure();
    test_random(1100);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("weighted_sampling_tree_engine: match");
    end else begin
      $display("weighted_sampling_tree_engine: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/wste_pkg.sv
design/wste_front.sv
design/wste_queue.sv
design/wste_back.sv
design/weighted_sampling_tree_engine.sv
verif/tb_weighted_sampling_tree_engine.sv
